### rtl/core/average_pool_2d_stream_unit_assert.svh
// ----------------------------------------------------------------------------
// average_pool_2d_stream_unit_assert.svh
// assertion macros used by the pooling unit checker
// ----------------------------------------------------------------------------
`ifndef AVERAGE_POOL_2D_STREAM_UNIT_ASSERT_SVH
`define AVERAGE_POOL_2D_STREAM_UNIT_ASSERT_SVH

// property checked on clk_i, ignored while rst_ni is low
`define APOOL_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("apool assertion failed");

// condition in one cycle implies a condition in the next
`define APOOL_ASSERT_NEXT(name, cond, nxt) \
  `APOOL_ASSERT(name, (cond) |=> (nxt))

`endif

### rtl/core/apool_pkg.sv
// ----------------------------------------------------------------------------
// apool_pkg
// types and constants of the streaming average pooling unit
// ----------------------------------------------------------------------------
package apool_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_ROWS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_COLS = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_TOP     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_LEFT    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_BOTTOM  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_RIGHT   = 4'd7;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_CHK  = 10'b00_0000_0010,
    S_DIVR = 10'b00_0000_0100,
    S_DIVC = 10'b00_0000_1000,
    S_DIVH = 10'b00_0001_0000,
    S_DIVW = 10'b00_0010_0000,
    S_READ = 10'b00_0100_0000,
    S_CNT  = 10'b00_1000_0000,
    S_DIVS = 10'b01_0000_0000,
    S_EMIT = 10'b10_0000_0000
  } state_e;

  // handshake between the sequencer and the divider
  typedef struct packed {
    logic start;
    logic done;
  } div_ctrl_t;

endpackage

### rtl/core/apool_div.sv
// ----------------------------------------------------------------------------
// apool_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module apool_div #(
  parameter int W = 21
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  apool_pkg::div_ctrl_t  ctrl_i,
  output apool_pkg::div_ctrl_t  ctrl_o,
  input  logic [W-1:0]          dividend_i,
  input  logic [W-1:0]          divisor_i,
  output logic [W-1:0]          quotient_o,
  output logic [W-1:0]          remainder_o
);
  import apool_pkg::*;

  localparam int CNW = (W > 1) ? $clog2(W) : 1;

  logic           busy_q, done_q;
  logic [CNW-1:0] cnt_q;
  logic [W-1:0]   rem_q, quo_q, dvs_q;
  logic [W:0]     trial;
  logic           ge;

  assign trial = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};
  assign ge    = !trial[W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNW'(W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? trial[W-1:0] : {rem_q[W-2:0], quo_q[W-1]};
      quo_q <= {quo_q[W-2:0], ge};
    end
  end

  assign ctrl_o.start = 1'b0;
  assign ctrl_o.done  = done_q;
  assign quotient_o   = quo_q;
  assign remainder_o  = rem_q;

endmodule

### rtl/core/average_pool_2d_stream_unit.sv
// ----------------------------------------------------------------------------
// average_pool_2d_stream_unit
// streaming 2d average pooling over one padded channel plane
// ----------------------------------------------------------------------------
// Samples enter in raster order and are written into a line store of
// KERNEL_H rows; every window on the stride grid whose bottom-right sample
// arrives emits the window sum divided by its valid-position count, truncated
// toward zero and saturated, with divide_error_o set (and average 0) when that
// count is zero. One item is worked on at a time. A sample that closes no
// window is done after the window check; one whose window origin is off the
// stride grid after the row and column stride divisions; one that emits a
// result also runs the output-size divisions, the window read and, unless the
// count is zero, the mean division, and waits out any output stall. Its pace
// is set by the shared bit-serial divider, which resolves the stride grid, the
// output size and the mean, and by the single read port of the line store,
// which gives one window sample per cycle. The line store needs no clearing
// after reset.
module average_pool_2d_stream_unit #(
  parameter int KERNEL_H    = 3,
  parameter int KERNEL_W    = 3,
  parameter int MAX_COLS    = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [apool_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [apool_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]      sample_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]      average_o,
  output logic                               divide_error_o,
  output logic                               last_of_plane_o
);
  import apool_pkg::*;

  localparam int KN   = KERNEL_H * KERNEL_W;
  localparam int RB   = (KERNEL_H > 1) ? $clog2(KERNEL_H) : 1;
  localparam int KCB  = (KERNEL_W > 1) ? $clog2(KERNEL_W) : 1;
  localparam int CB   = $clog2(MAX_COLS);
  localparam int CLW0 = $clog2(MAX_COLS + 1);
  localparam int CLW  = (CLW0 > 9) ? CLW0 : 9;
  localparam int SW   = SAMPLE_BITS + $clog2(KN) + 1;
  localparam int DW   = (SW > CLW + 1) ? SW : CLW + 1;
  localparam int SPW  = CLW + 3;
  localparam int NW   = $clog2(KN + 1);

  localparam logic signed [SPW-1:0] KH_M1 = SPW'(KERNEL_H - 1);
  localparam logic signed [SPW-1:0] KW_M1 = SPW'(KERNEL_W - 1);
  localparam logic signed [SPW-1:0] S_ONE = SPW'(1);

  // configuration
  logic [7:0] stride_rows_q, stride_cols_q;
  logic [8:0] frame_rows_q, frame_cols_q;
  logic [7:0] pad_top_q, pad_left_q, pad_bottom_q, pad_right_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_rows_q <= 8'd1;
      stride_cols_q <= 8'd1;
      frame_rows_q  <= 9'd256;
      frame_cols_q  <= 9'd256;
      pad_top_q     <= '0;
      pad_left_q    <= '0;
      pad_bottom_q  <= '0;
      pad_right_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_STRIDE_ROWS: stride_rows_q <= cfg_data_i[7:0];
        CFG_STRIDE_COLS: stride_cols_q <= cfg_data_i[7:0];
        CFG_FRAME_ROWS:  frame_rows_q  <= cfg_data_i;
        CFG_FRAME_COLS:  frame_cols_q  <= cfg_data_i;
        CFG_PAD_TOP:     pad_top_q     <= cfg_data_i[7:0];
        CFG_PAD_LEFT:    pad_left_q    <= cfg_data_i[7:0];
        CFG_PAD_BOTTOM:  pad_bottom_q  <= cfg_data_i[7:0];
        CFG_PAD_RIGHT:   pad_right_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  logic [7:0]     sr, sc;
  logic [8:0]     rows;
  logic [CLW-1:0] fcx, cols;

  assign sr   = (stride_rows_q == '0) ? 8'd1 : stride_rows_q;
  assign sc   = (stride_cols_q == '0) ? 8'd1 : stride_cols_q;
  assign rows = (frame_rows_q == '0) ? 9'd1 : frame_rows_q;
  assign fcx  = (frame_cols_q == '0) ? CLW'(1) : CLW'(frame_cols_q);
  assign cols = (fcx > CLW'(MAX_COLS)) ? CLW'(MAX_COLS) : fcx;

  // raster position
  state_e         state_q, state_d;
  logic [8:0]     in_row_q, in_row_d, erow;
  logic [CB-1:0]  in_col_q, in_col_d, ecol;
  logic [RB-1:0]  rmod_q, rmod_d, rmod_e;
  logic           accept;
  logic [CLW-1:0] col_nx;
  logic [9:0]     row_nx;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign erow       = (in_row_q >= rows) ? 9'd0 : in_row_q;
  assign rmod_e     = (in_row_q >= rows) ? '0 : rmod_q;
  assign ecol       = (CLW'(in_col_q) >= cols) ? '0 : in_col_q;
  assign col_nx     = CLW'(ecol) + CLW'(1);
  assign row_nx     = {1'b0, erow} + 10'd1;

  always_comb begin
    in_row_d = in_row_q;
    in_col_d = in_col_q;
    rmod_d   = rmod_q;
    if (accept) begin
      in_row_d = erow;
      rmod_d   = rmod_e;
      if (col_nx >= cols) begin
        in_col_d = '0;
        if (row_nx >= {1'b0, rows}) begin
          in_row_d = '0;
          rmod_d   = '0;
        end else begin
          in_row_d = row_nx[8:0];
          rmod_d   = (rmod_e == RB'(KERNEL_H - 1)) ? '0 : rmod_e + 1'b1;
        end
      end else begin
        in_col_d = col_nx[CB-1:0];
      end
    end
  end

  // line store
  logic signed [SAMPLE_BITS-1:0] mem [KERNEL_H][MAX_COLS];
  logic signed [SAMPLE_BITS-1:0] rd_data_q;
  logic [RB-1:0]                 rd_r_q;
  logic [KCB-1:0]                rd_c_q;
  logic                          rd_issue_q, rd_v_q;
  logic [CB-1:0]                 rd_addr;
  logic [CB-1:0]                 c0_q;
  logic                          rd_en;

  assign rd_addr = c0_q + CB'(rd_c_q);
  assign rd_en   = (state_q == S_READ) && rd_issue_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem[rmod_e][ecol] <= sample_i;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_r_q][rd_addr];
    end
  end

  // divider
  div_ctrl_t      div_in, div_out;
  logic [DW-1:0]  div_a, div_b, div_q, div_r;
  logic           div_issued_q, div_issued_d;
  logic           div_state;

  apool_div #(.W(DW)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (div_in),
    .ctrl_o      (div_out),
    .dividend_i  (div_a),
    .divisor_i   (div_b),
    .quotient_o  (div_q),
    .remainder_o (div_r)
  );

  // window bookkeeping
  logic                    cand_q;
  logic [8:0]              r0_q, orow_q, oh_q;
  logic [CB-1:0]           ocol_q;
  logic [CLW-1:0]          ow_q;
  logic                    rrem_nz_q;
  logic signed [SW-1:0]    sum_q;
  logic [NW-1:0]           count_q, count_d;
  logic                    err_q, last_q, last_d;
  logic                    neg;
  logic [SW-1:0]           mag;

  assign neg = sum_q[SW-1];
  assign mag = neg ? SW'(-sum_q) : SW'(sum_q);

  always_comb begin
    unique case (state_q)
      S_DIVR: begin div_a = DW'(r0_q); div_b = DW'(sr); end
      S_DIVC: begin div_a = DW'(c0_q); div_b = DW'(sc); end
      S_DIVH: begin div_a = DW'(rows - 9'(KERNEL_H)); div_b = DW'(sr); end
      S_DIVW: begin div_a = DW'(cols - CLW'(KERNEL_W)); div_b = DW'(sc); end
      default: begin div_a = DW'(mag); div_b = DW'(count_q); end
    endcase
  end

  assign div_state    = (state_q == S_DIVR) || (state_q == S_DIVC) || (state_q == S_DIVH)
                     || (state_q == S_DIVW) || (state_q == S_DIVS);
  assign div_in.start = div_state && !div_issued_q;
  assign div_in.done  = 1'b0;
  assign div_issued_d = div_state ? (div_issued_q ? !div_out.done : 1'b1) : 1'b0;

  // valid-position count
  logic signed [SPW-1:0] orow_s, ocol_s, oh_s, ow_s, r0_s, c0_s, rows_s, cols_s;
  logic signed [SPW-1:0] pt_s, pl_s, pb_s, pr_s;
  logic signed [SPW-1:0] fr, lr, fc, lc, dr, dc;
  logic                  in_m;
  logic [7:0]            prod;

  assign orow_s = SPW'(orow_q);
  assign ocol_s = SPW'(ocol_q);
  assign oh_s   = SPW'(oh_q);
  assign ow_s   = SPW'(ow_q);
  assign r0_s   = SPW'(r0_q);
  assign c0_s   = SPW'(c0_q);
  assign rows_s = SPW'(rows);
  assign cols_s = SPW'(cols);
  assign pt_s   = SPW'(pad_top_q);
  assign pl_s   = SPW'(pad_left_q);
  assign pb_s   = SPW'(pad_bottom_q);
  assign pr_s   = SPW'(pad_right_q);

  assign in_m = (orow_s >= pt_s) && (orow_s < oh_s - pb_s)
             && (ocol_s >= pl_s) && (ocol_s < ow_s - pr_s);
  assign fr   = (r0_s > pt_s) ? r0_s : pt_s;
  assign lr   = (r0_s + KH_M1 < rows_s - pb_s - S_ONE) ? r0_s + KH_M1 : rows_s - pb_s - S_ONE;
  assign fc   = (c0_s > pl_s) ? c0_s : pl_s;
  assign lc   = (c0_s + KW_M1 < cols_s - pr_s - S_ONE) ? c0_s + KW_M1 : cols_s - pr_s - S_ONE;
  assign dr   = lr - fr + S_ONE;
  assign dc   = lc - fc + S_ONE;
  assign prod = dr[3:0] * dc[3:0];

  always_comb begin
    if (in_m) begin
      count_d = NW'(KN);
    end else if (dr > 0 && dc > 0) begin
      count_d = NW'(prod);
    end else begin
      count_d = '0;
    end
  end

  assign last_d = ({1'b0, orow_q} + 10'd1 == {1'b0, oh_q})
               && (CLW'(ocol_q) + CLW'(1) == ow_q);

  // truncation and saturation of the mean
  localparam logic [DW-1:0] Q_MAX = {(DW - SAMPLE_BITS + 1)'(0), {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic [DW-1:0] Q_MIN = DW'(1) << (SAMPLE_BITS - 1);
  localparam logic [SAMPLE_BITS-1:0] A_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] A_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  logic [SAMPLE_BITS-1:0] avg_res;
  logic [SAMPLE_BITS-1:0] res_q;

  always_comb begin
    if (!neg) begin
      avg_res = (div_q > Q_MAX) ? A_MAX : div_q[SAMPLE_BITS-1:0];
    end else begin
      avg_res = (div_q > Q_MIN) ? A_MIN : -div_q[SAMPLE_BITS-1:0];
    end
  end

  // sequencer
  logic out_valid_q, out_pop, out_load;

  assign out_pop  = out_valid_q && !out_stall_i;
  assign out_load = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_CHK;
      S_CHK:  state_d = cand_q ? S_DIVR : S_IDLE;
      S_DIVR: if (div_out.done) state_d = S_DIVC;
      S_DIVC: begin
        if (div_out.done) begin
          state_d = (rrem_nz_q || div_r != '0) ? S_IDLE : S_DIVH;
        end
      end
      S_DIVH: if (div_out.done) state_d = S_DIVW;
      S_DIVW: if (div_out.done) state_d = S_READ;
      S_READ: if (!rd_issue_q && rd_v_q) state_d = S_CNT;
      S_CNT:  state_d = (count_d == '0) ? S_EMIT : S_DIVS;
      S_DIVS: if (div_out.done) state_d = S_EMIT;
      S_EMIT: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      in_row_q     <= '0;
      in_col_q     <= '0;
      rmod_q       <= '0;
      div_issued_q <= 1'b0;
      rd_issue_q   <= 1'b0;
      rd_v_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      in_row_q     <= in_row_d;
      in_col_q     <= in_col_d;
      rmod_q       <= rmod_d;
      div_issued_q <= div_issued_d;
      rd_v_q       <= rd_en;
      if (state_q == S_DIVW && div_out.done) begin
        rd_issue_q <= 1'b1;
      end else if (rd_en && rd_r_q == RB'(KERNEL_H - 1) && rd_c_q == KCB'(KERNEL_W - 1)) begin
        rd_issue_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload and window registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cand_q <= ({1'b0, erow} + 10'd1 >= 10'(KERNEL_H))
             && (CLW'(ecol) + CLW'(1) >= CLW'(KERNEL_W));
      r0_q   <= 9'({1'b0, erow} + 10'd1 - 10'(KERNEL_H));
      c0_q   <= CB'(CLW'(ecol) + CLW'(1) - CLW'(KERNEL_W));
    end
    if (div_out.done) begin
      unique case (state_q)
        S_DIVR:  begin orow_q <= div_q[8:0]; rrem_nz_q <= (div_r != '0); end
        S_DIVC:  ocol_q <= div_q[CB-1:0];
        S_DIVH:  oh_q <= div_q[8:0] + 9'd1;
        S_DIVW:  ow_q <= div_q[CLW-1:0] + CLW'(1);
        S_DIVS:  res_q <= avg_res;
        default: ;
      endcase
    end
    if (state_q == S_DIVW && div_out.done) begin
      rd_r_q <= '0;
      rd_c_q <= '0;
      sum_q  <= '0;
    end else if (state_q == S_READ) begin
      if (rd_en) begin
        if (rd_c_q == KCB'(KERNEL_W - 1)) begin
          rd_c_q <= '0;
          rd_r_q <= rd_r_q + 1'b1;
        end else begin
          rd_c_q <= rd_c_q + 1'b1;
        end
      end
      if (rd_v_q) begin
        sum_q <= sum_q + SW'(rd_data_q);
      end
    end
    if (state_q == S_CNT) begin
      count_q <= count_d;
      err_q   <= (count_d == '0);
      last_q  <= last_d;
      if (count_d == '0) begin
        res_q <= '0;
      end
    end
  end

  logic [SAMPLE_BITS-1:0] avg_out_q;
  logic                   err_out_q, last_out_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      avg_out_q  <= res_q;
      err_out_q  <= err_q;
      last_out_q <= last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign average_o       = avg_out_q;
  assign divide_error_o  = err_out_q;
  assign last_of_plane_o = last_out_q;

endmodule

### rtl/core/apool_check.sv
// ----------------------------------------------------------------------------
// apool_check
// port-level checks of the streaming average pooling unit
// ----------------------------------------------------------------------------
`include "average_pool_2d_stream_unit_assert.svh"

module apool_check #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              cfg_valid_i,
  input logic                              cfg_ready_o,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [SAMPLE_BITS-1:0]     average_o,
  input logic                              divide_error_o,
  input logic                              last_of_plane_o
);

  logic in_xact, out_hold;

  assign in_xact  = in_valid_i && !in_stall_o;
  assign out_hold = out_valid_o && out_stall_i;

  // a stalled result stays offered
  `APOOL_ASSERT_NEXT(a_out_hold, out_hold, out_valid_o)
  // a stalled result keeps its payload
  `APOOL_ASSERT_NEXT(a_out_stable, out_hold,
    $stable(average_o) && $stable(divide_error_o) && $stable(last_of_plane_o))
  // every accepted sample stalls the input in the next cycle
  `APOOL_ASSERT_NEXT(a_busy_after_in, in_xact, in_stall_o)
  // a failed division reports zero
  `APOOL_ASSERT(a_err_zero, (out_valid_o && divide_error_o) |-> (average_o == '0))
  // the configuration port never back-pressures
  `APOOL_ASSERT(a_cfg_ready, cfg_valid_i |-> cfg_ready_o)

endmodule

bind average_pool_2d_stream_unit apool_check #(.SAMPLE_BITS(SAMPLE_BITS)) u_apool_check (.*);
